@@ rtl/tsm_pkg.sv @@
// Shared types and constants for the tagged stack machine core.
`default_nettype none

package tsm_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DEC,
        ST_RD2,
        ST_RD3,
        ST_EXEC,
        ST_DIV,
        ST_DIVW,
        ST_WR2,
        ST_DONE
    } state_t;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EXEC = 1'b1;

    // Opcodes
    localparam logic [4:0] OP_PUSH = 5'd0;
    localparam logic [4:0] OP_POP  = 5'd1;
    localparam logic [4:0] OP_DUP  = 5'd2;
    localparam logic [4:0] OP_ADD  = 5'd3;
    localparam logic [4:0] OP_SUB  = 5'd4;
    localparam logic [4:0] OP_MUL  = 5'd5;
    localparam logic [4:0] OP_DIV  = 5'd6;
    localparam logic [4:0] OP_JMP  = 5'd7;
    localparam logic [4:0] OP_JIT  = 5'd8;
    localparam logic [4:0] OP_JIF  = 5'd9;
    localparam logic [4:0] OP_CALL = 5'd10;
    localparam logic [4:0] OP_RET  = 5'd11;
    localparam logic [4:0] OP_EQ   = 5'd12;
    localparam logic [4:0] OP_GT   = 5'd13;
    localparam logic [4:0] OP_GE   = 5'd14;
    localparam logic [4:0] OP_LT   = 5'd15;
    localparam logic [4:0] OP_LE   = 5'd16;
    localparam logic [4:0] OP_NE   = 5'd17;
    localparam logic [4:0] OP_STO  = 5'd18;
    localparam logic [4:0] OP_RCL  = 5'd19;
    localparam logic [4:0] OP_END  = 5'd20;
    localparam logic [4:0] OP_PRN  = 5'd21;
    localparam logic [4:0] OP_STL  = 5'd22;
    localparam logic [4:0] OP_RCE  = 5'd23;
    localparam logic [4:0] OP_ALC  = 5'd24;
    localparam logic [4:0] OP_FRE  = 5'd25;

    // Offset added to STO/RCL addresses
    localparam int MEM_OFFSET = 6;

endpackage

`default_nettype wire

@@ rtl/tsm_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/tagged_stack_machine_core.sv @@
// Tagged stack machine core: sequencer, stack/frame logic and RAM instances.
//
//  channel   | signals                                          | dir | handshake
//  ----------+--------------------------------------------------+-----+----------------------
//  command   | cmd load_addr load_opcode load_is_num load_value | in  | start & !busy
//  result    | instr_ptr halted print_valid print_is_num        | out | done, one cycle
//            | print_value fault                                |     |
//
//  A load beat goes from accept straight to done. An execute beat steps through
//  fetch, decode, two stack read states, execute and done; CALL adds a
//  second call stack write, and DIV adds a divide phase (one quotient bit a
//  cycle) and a quotient push. A halted execute beat goes straight to done.
//  The sequence follows the registered reads of the program and stack RAMs,
//  read in sequence; the next beat can be accepted in the cycle after done.
//  Reset clears pointers and halt flag; the RAMs are not cleared. The
//  result receiver cannot stall; busy stays high until done has been shown.
`default_nettype none

module tagged_stack_machine_core #(
    parameter int PROG_DEPTH  = 256,
    parameter int STACK_DEPTH = 64,
    parameter int MEM_DEPTH   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cmd,
    input  wire logic [7:0]         load_addr,
    input  wire logic [4:0]         load_opcode,
    input  wire logic               load_is_num,
    input  wire logic signed [31:0] load_value,
    output logic                    done,
    output logic [7:0]              instr_ptr,
    output logic                    halted,
    output logic                    print_valid,
    output logic                    print_is_num,
    output logic signed [31:0]      print_value,
    output logic                    fault
);

    localparam int VW  = VALUE_WIDTH;
    localparam int WW  = VW + 1;
    localparam int PWW = 5 + 1 + VW;
    localparam int PW  = $clog2(PROG_DEPTH);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int MW  = $clog2(MEM_DEPTH);
    localparam int CW  = VW + 14;
    localparam int CNW = $clog2(VW + 1);

    localparam logic signed [CW-1:0] PDX  = CW'(PROG_DEPTH);
    localparam logic signed [CW-1:0] SDX  = CW'(STACK_DEPTH);
    localparam logic signed [CW-1:0] MDX  = CW'(MEM_DEPTH);
    localparam logic signed [CW-1:0] OFSX = CW'(tsm_pkg::MEM_OFFSET);
    localparam logic [SW:0]          SDC  = (SW + 1)'(STACK_DEPTH);

    // Registers
    tsm_pkg::state_t state_reg, state_next;
    logic [PW-1:0]   ip_reg, ip_next;
    logic [SW:0]     dtop_reg, dtop_next;
    logic [SW:0]     ctop_reg, ctop_next;
    logic [SW:0]     fb_reg, fb_next;
    logic            halt_reg, halt_next;
    logic [4:0]      op_reg, op_next;
    logic            tag_reg, tag_next;
    logic [VW-1:0]   val_reg, val_next;
    logic [WW-1:0]   a_reg, a_next;
    logic [WW-1:0]   b_reg, b_next;
    logic [WW-1:0]   c1_reg, c1_next;
    logic [WW-1:0]   d_reg, d_next;
    logic [WW-1:0]   cs_wdat_reg, cs_wdat_next;
    logic            pv_reg, pv_next;
    logic            ptag_reg, ptag_next;
    logic [VW-1:0]   pval_reg, pval_next;
    logic            fault_reg, fault_next;
    logic [VW-1:0]   dq_reg, dq_next;
    logic [VW-1:0]   drem_reg, drem_next;
    logic [VW-1:0]   dden_reg, dden_next;
    logic            dneg_reg, dneg_next;
    logic [CNW-1:0]  dcnt_reg, dcnt_next;

    // RAM ports
    logic            prog_we;
    logic [PWW-1:0]  prog_wdata, prog_rdata;
    logic [PW-1:0]   prog_waddr;
    logic            ds_we;
    logic [SW-1:0]   ds_waddr, ds_raddr;
    logic [WW-1:0]   ds_wdata, ds_rdata;
    logic            cs_we;
    logic [SW-1:0]   cs_waddr, cs_raddr;
    logic [WW-1:0]   cs_wdata, cs_rdata;
    logic            dm_we;
    logic [MW-1:0]   dm_waddr, dm_raddr;
    logic [WW-1:0]   dm_wdata, dm_rdata;

    // Operand views
    logic [VW-1:0]   a_val, b_val;
    logic            a_tag, b_tag;
    logic [VW-1:0]   alu;
    logic [VW:0]     div_trial;
    logic            div_fit;

    // Wide signed address arithmetic
    logic signed [CW-1:0] sx, fbx, ctx, t_addr, l_addr, alc_top, fre_top, nb_x, ni_x;
    logic                 tgt_ok, t_in, l_in, alc_ok, fre_ok, ret_ok;

    // Execute-cycle scratch
    logic            jump, push_req, div_go, call_go;
    logic [WW-1:0]   push_word;
    logic [SW:0]     dbase;
    logic [PW-1:0]   ipx;
    logic            cond_ok;

    function automatic logic [PW-1:0] ip_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(PROG_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    // Memories
    tsm_ram #(.WIDTH(PWW), .DEPTH(PROG_DEPTH)) u_prog (
        .clk(clk), .we(prog_we), .waddr(prog_waddr), .wdata(prog_wdata),
        .raddr(ip_reg), .rdata(prog_rdata)
    );

    tsm_ram #(.WIDTH(WW), .DEPTH(STACK_DEPTH)) u_dstack (
        .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .raddr(ds_raddr), .rdata(ds_rdata)
    );

    tsm_ram #(.WIDTH(WW), .DEPTH(STACK_DEPTH)) u_cstack (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata)
    );

    tsm_ram #(.WIDTH(WW), .DEPTH(MEM_DEPTH)) u_dmem (
        .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_rdata)
    );

    // Program word load path
    assign prog_waddr = PW'(load_addr);
    assign prog_wdata = {load_opcode, load_is_num, VW'(load_value)};

    // Operands
    assign a_tag = a_reg[VW];
    assign a_val = a_reg[VW-1:0];
    assign b_tag = b_reg[VW];
    assign b_val = b_reg[VW-1:0];

    // Address and range checks
    assign sx      = CW'($signed(val_reg));
    assign fbx     = $signed(CW'(fb_reg));
    assign ctx     = $signed(CW'(ctop_reg));
    assign t_addr  = sx + OFSX;
    assign l_addr  = sx + fbx - CW'(1);
    assign alc_top = ctx + sx;
    assign fre_top = ctx - sx;
    assign nb_x    = CW'($signed(c1_reg[VW-1:0]));
    assign ni_x    = CW'($signed(cs_rdata[VW-1:0]));
    assign tgt_ok  = (sx >= 0) && (sx < PDX);
    assign t_in    = (t_addr >= 0) && (t_addr < MDX);
    assign l_in    = (l_addr >= 0) && (l_addr < SDX);
    assign alc_ok  = (alc_top >= 0) && (alc_top <= SDX);
    assign fre_ok  = (fre_top >= 0) && (fre_top <= SDX);
    assign ret_ok  = (fb_reg >= (SW + 1)'(2)) && (fb_reg <= SDC) &&
                     (nb_x >= 0) && (nb_x <= SDX) && (ni_x >= 0) && (ni_x < PDX);

    // Arithmetic and compare unit
    always_comb
    begin
        unique case (op_reg)
            tsm_pkg::OP_ADD: alu = b_val + a_val;
            tsm_pkg::OP_SUB: alu = b_val - a_val;
            tsm_pkg::OP_MUL: alu = b_val * a_val;
            tsm_pkg::OP_EQ:  alu = VW'(a_val == b_val);
            tsm_pkg::OP_GT:  alu = VW'($signed(a_val) < $signed(b_val));
            tsm_pkg::OP_GE:  alu = VW'(!($signed(b_val) < $signed(a_val)));
            tsm_pkg::OP_LT:  alu = VW'($signed(b_val) < $signed(a_val));
            tsm_pkg::OP_LE:  alu = VW'(!($signed(a_val) < $signed(b_val)));
            tsm_pkg::OP_NE:  alu = VW'(a_val != b_val);
            default:         alu = '0;
        endcase
    end

    // Divider step
    assign div_trial = {drem_reg, dq_reg[VW-1]};
    assign div_fit   = div_trial >= {1'b0, dden_reg};

    // State and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsm_pkg::ST_IDLE;
            ip_reg    <= '0;
            dtop_reg  <= '0;
            ctop_reg  <= '0;
            fb_reg    <= '0;
            halt_reg  <= 1'b0;
            pv_reg    <= 1'b0;
            fault_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ip_reg    <= ip_next;
            dtop_reg  <= dtop_next;
            ctop_reg  <= ctop_next;
            fb_reg    <= fb_next;
            halt_reg  <= halt_next;
            pv_reg    <= pv_next;
            fault_reg <= fault_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        tag_reg     <= tag_next;
        val_reg     <= val_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c1_reg      <= c1_next;
        d_reg       <= d_next;
        cs_wdat_reg <= cs_wdat_next;
        ptag_reg    <= ptag_next;
        pval_reg    <= pval_next;
        dq_reg      <= dq_next;
        drem_reg    <= drem_next;
        dden_reg    <= dden_next;
        dneg_reg    <= dneg_next;
        dcnt_reg    <= dcnt_next;
    end

    // Sequencer: next state, RAM control and instruction execution
    always_comb
    begin
        state_next   = state_reg;
        ip_next      = ip_reg;
        dtop_next    = dtop_reg;
        ctop_next    = ctop_reg;
        fb_next      = fb_reg;
        halt_next    = halt_reg;
        op_next      = op_reg;
        tag_next     = tag_reg;
        val_next     = val_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c1_next      = c1_reg;
        d_next       = d_reg;
        cs_wdat_next = cs_wdat_reg;
        pv_next      = pv_reg;
        ptag_next    = ptag_reg;
        pval_next    = pval_reg;
        fault_next   = fault_reg;
        dq_next      = dq_reg;
        drem_next    = drem_reg;
        dden_next    = dden_reg;
        dneg_next    = dneg_reg;
        dcnt_next    = dcnt_reg;

        prog_we  = 1'b0;
        ds_we    = 1'b0;
        ds_waddr = '0;
        ds_wdata = '0;
        ds_raddr = '0;
        cs_we    = 1'b0;
        cs_waddr = '0;
        cs_wdata = '0;
        cs_raddr = '0;
        dm_we    = 1'b0;
        dm_waddr = '0;
        dm_wdata = '0;
        dm_raddr = '0;

        jump      = 1'b0;
        push_req  = 1'b0;
        push_word = '0;
        div_go    = 1'b0;
        call_go   = 1'b0;
        dbase     = dtop_reg;
        ipx       = ip_reg;
        cond_ok   = 1'b0;

        unique case (state_reg)
            tsm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    pv_next    = 1'b0;
                    ptag_next  = 1'b0;
                    pval_next  = '0;
                    fault_next = 1'b0;
                    if (cmd == tsm_pkg::CMD_LOAD)
                    begin
                        prog_we    = (32'(load_addr) < 32'(PROG_DEPTH));
                        state_next = tsm_pkg::ST_DONE;
                    end
                    else if (halt_reg)
                    begin
                        state_next = tsm_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tsm_pkg::ST_FETCH;
                    end
                end
            end

            // Program RAM read in flight
            tsm_pkg::ST_FETCH:
            begin
                state_next = tsm_pkg::ST_DEC;
            end

            // Latch instruction, read top of data stack
            tsm_pkg::ST_DEC:
            begin
                op_next    = prog_rdata[PWW-1 -: 5];
                tag_next   = prog_rdata[VW];
                val_next   = prog_rdata[VW-1:0];
                ds_raddr   = SW'(dtop_reg - (SW + 1)'(1));
                state_next = tsm_pkg::ST_RD2;
            end

            // Second operand, frame slot and data memory reads
            tsm_pkg::ST_RD2:
            begin
                a_next   = ds_rdata;
                ds_raddr = SW'(dtop_reg - (SW + 1)'(2));
                if (op_reg == tsm_pkg::OP_RET)
                begin
                    cs_raddr = SW'(fb_reg - (SW + 1)'(1));
                end
                else
                begin
                    cs_raddr = SW'(l_addr);
                end
                dm_raddr   = MW'(t_addr);
                state_next = tsm_pkg::ST_RD3;
            end

            // Saved return pointer read
            tsm_pkg::ST_RD3:
            begin
                b_next     = ds_rdata;
                c1_next    = cs_rdata;
                d_next     = dm_rdata;
                cs_raddr   = SW'(fb_reg - (SW + 1)'(2));
                state_next = tsm_pkg::ST_EXEC;
            end

            tsm_pkg::ST_EXEC:
            begin
                unique case (op_reg)
                    tsm_pkg::OP_PUSH:
                    begin
                        push_req  = 1'b1;
                        push_word = {tag_reg, val_reg};
                    end

                    tsm_pkg::OP_POP:
                    begin
                        if (dtop_reg == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            dbase = dtop_reg - (SW + 1)'(1);
                        end
                    end

                    // Pop then push twice: same as one push over the top
                    tsm_pkg::OP_DUP:
                    begin
                        if (dtop_reg == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            push_req  = 1'b1;
                            push_word = a_reg;
                        end
                    end

                    tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV,
                    tsm_pkg::OP_EQ, tsm_pkg::OP_GT, tsm_pkg::OP_GE, tsm_pkg::OP_LT,
                    tsm_pkg::OP_LE, tsm_pkg::OP_NE:
                    begin
                        if (dtop_reg < (SW + 1)'(2))
                        begin
                            fault_next = 1'b1;
                            dbase      = '0;
                        end
                        else
                        begin
                            dbase = dtop_reg - (SW + 1)'(2);
                            if (a_tag && b_tag)
                            begin
                                if (op_reg == tsm_pkg::OP_DIV)
                                begin
                                    if (a_val == '0)
                                    begin
                                        fault_next = 1'b1;
                                    end
                                    else
                                    begin
                                        div_go = 1'b1;
                                    end
                                end
                                else
                                begin
                                    push_req  = 1'b1;
                                    push_word = {1'b1, alu};
                                end
                            end
                        end
                    end

                    tsm_pkg::OP_JMP, tsm_pkg::OP_JIT, tsm_pkg::OP_JIF:
                    begin
                        if (op_reg == tsm_pkg::OP_JMP)
                        begin
                            cond_ok = 1'b1;
                        end
                        else if (dtop_reg == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            dbase   = dtop_reg - (SW + 1)'(1);
                            cond_ok = (op_reg == tsm_pkg::OP_JIT) ? (a_val != '0)
                                                                  : (a_val == '0);
                        end
                        if (cond_ok)
                        begin
                            if (tgt_ok)
                            begin
                                ipx  = PW'(sx);
                                jump = 1'b1;
                            end
                            else
                            begin
                                fault_next = 1'b1;
                            end
                        end
                    end

                    // Save return pointer here, frame base in the next cycle
                    tsm_pkg::OP_CALL:
                    begin
                        if (!tgt_ok || (ctx + CW'(2) > SDX))
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            cs_we        = 1'b1;
                            cs_waddr     = SW'(ctop_reg);
                            cs_wdata     = {1'b1, VW'(ip_reg)};
                            cs_wdat_next = {1'b1, VW'(fb_reg)};
                            ctop_next    = ctop_reg + (SW + 1)'(2);
                            fb_next      = ctop_reg + (SW + 1)'(2);
                            ipx          = PW'(sx);
                            jump         = 1'b1;
                            call_go      = 1'b1;
                        end
                    end

                    // Restore frame; pointer then advances past the call
                    tsm_pkg::OP_RET:
                    begin
                        if (ret_ok)
                        begin
                            ctop_next = fb_reg - (SW + 1)'(2);
                            fb_next   = (SW + 1)'(nb_x);
                            ipx       = PW'(ni_x);
                        end
                        else
                        begin
                            fault_next = 1'b1;
                        end
                    end

                    tsm_pkg::OP_STO:
                    begin
                        if (dtop_reg == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            dbase = dtop_reg - (SW + 1)'(1);
                            if (t_in)
                            begin
                                dm_we    = 1'b1;
                                dm_waddr = MW'(t_addr);
                                dm_wdata = a_reg;
                            end
                            else
                            begin
                                fault_next = 1'b1;
                            end
                        end
                    end

                    tsm_pkg::OP_RCL:
                    begin
                        if (t_in)
                        begin
                            push_req  = 1'b1;
                            push_word = d_reg;
                        end
                        else
                        begin
                            fault_next = 1'b1;
                        end
                    end

                    tsm_pkg::OP_END:
                    begin
                        halt_next = 1'b1;
                        jump      = 1'b1;
                    end

                    tsm_pkg::OP_PRN:
                    begin
                        if (dtop_reg == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            dbase     = dtop_reg - (SW + 1)'(1);
                            pv_next   = 1'b1;
                            ptag_next = a_tag;
                            pval_next = a_val;
                        end
                    end

                    tsm_pkg::OP_STL:
                    begin
                        if (dtop_reg == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            dbase = dtop_reg - (SW + 1)'(1);
                            if (l_in)
                            begin
                                cs_we    = 1'b1;
                                cs_waddr = SW'(l_addr);
                                cs_wdata = a_reg;
                            end
                            else
                            begin
                                fault_next = 1'b1;
                            end
                        end
                    end

                    tsm_pkg::OP_RCE:
                    begin
                        if (l_in)
                        begin
                            push_req  = 1'b1;
                            push_word = c1_reg;
                        end
                        else
                        begin
                            fault_next = 1'b1;
                        end
                    end

                    tsm_pkg::OP_ALC:
                    begin
                        if (alc_ok)
                        begin
                            ctop_next = (SW + 1)'(alc_top);
                        end
                        else
                        begin
                            fault_next = 1'b1;
                        end
                    end

                    tsm_pkg::OP_FRE:
                    begin
                        if (fre_ok)
                        begin
                            ctop_next = (SW + 1)'(fre_top);
                        end
                        else
                        begin
                            fault_next = 1'b1;
                        end
                    end

                    default:
                    begin
                        jump = 1'b0;
                    end
                endcase

                // Common push onto the data stack
                dtop_next = dbase;
                if (push_req)
                begin
                    if (dbase < SDC)
                    begin
                        ds_we     = 1'b1;
                        ds_waddr  = SW'(dbase);
                        ds_wdata  = push_word;
                        dtop_next = dbase + (SW + 1)'(1);
                    end
                    else
                    begin
                        fault_next = 1'b1;
                    end
                end

                if (!jump)
                begin
                    ipx = ip_inc(ipx);
                end
                ip_next = ipx;

                // Divider setup on magnitudes
                dq_next   = b_val[VW-1] ? (VW'(0) - b_val) : b_val;
                dden_next = a_val[VW-1] ? (VW'(0) - a_val) : a_val;
                drem_next = '0;
                dneg_next = a_val[VW-1] ^ b_val[VW-1];
                dcnt_next = CNW'(VW);

                priority if (div_go)
                begin
                    state_next = tsm_pkg::ST_DIV;
                end
                else if (call_go)
                begin
                    state_next = tsm_pkg::ST_WR2;
                end
                else
                begin
                    state_next = tsm_pkg::ST_DONE;
                end
            end

            // Restoring division, one quotient bit a cycle
            tsm_pkg::ST_DIV:
            begin
                if (div_fit)
                begin
                    drem_next = VW'(div_trial - {1'b0, dden_reg});
                end
                else
                begin
                    drem_next = VW'(div_trial);
                end
                dq_next   = {dq_reg[VW-2:0], div_fit};
                dcnt_next = dcnt_reg - CNW'(1);
                if (dcnt_reg == CNW'(1))
                begin
                    state_next = tsm_pkg::ST_DIVW;
                end
            end

            // Push signed quotient
            tsm_pkg::ST_DIVW:
            begin
                ds_we      = 1'b1;
                ds_waddr   = SW'(dtop_reg);
                ds_wdata   = {1'b1, dneg_reg ? (VW'(0) - dq_reg) : dq_reg};
                dtop_next  = dtop_reg + (SW + 1)'(1);
                state_next = tsm_pkg::ST_DONE;
            end

            // Second call stack write: caller frame base
            tsm_pkg::ST_WR2:
            begin
                cs_we      = 1'b1;
                cs_waddr   = SW'(ctop_reg - (SW + 1)'(1));
                cs_wdata   = cs_wdat_reg;
                state_next = tsm_pkg::ST_DONE;
            end

            tsm_pkg::ST_DONE:
            begin
                state_next = tsm_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = tsm_pkg::ST_IDLE;
            end
        endcase
    end

    // Ports
    assign busy         = (state_reg != tsm_pkg::ST_IDLE);
    assign done         = (state_reg == tsm_pkg::ST_DONE);
    assign instr_ptr    = 8'(ip_reg);
    assign halted       = halt_reg;
    assign print_valid  = pv_reg;
    assign print_is_num = pv_reg & ptag_reg;
    assign print_value  = pv_reg ? $signed(32'(pval_reg)) : 32'sd0;
    assign fault        = fault_reg;

    // Assertions
    a_dtop_range: assert property (@(posedge clk) disable iff (!rst_n)
        dtop_reg <= SDC)
        else $error("data stack top out of range");

    a_ctop_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctop_reg <= SDC)
        else $error("call stack top out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(halt_reg))
        else $error("halt flag cleared");

endmodule

`default_nettype wire

@@ tb/sv/tagged_stack_machine_core_chk.sv @@
// Checker for the tagged stack machine core: predicts each beat and compares results.
`timescale 1ns / 100ps

module tagged_stack_machine_core_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               cmd,
    input  logic [7:0]         load_addr,
    input  logic [4:0]         load_opcode,
    input  logic               load_is_num,
    input  logic signed [31:0] load_value,
    input  logic               done,
    input  logic [7:0]         instr_ptr,
    input  logic               halted,
    input  logic               print_valid,
    input  logic               print_is_num,
    input  logic signed [31:0] print_value,
    input  logic               fault,
    output int                 fail_count,
    output int                 pending
);

    localparam int PROG_WORDS  = 256;
    localparam int STACK_WORDS = 64;
    localparam int MEM_WORDS   = 64;
    localparam int OFS         = tsm_pkg::MEM_OFFSET;

    typedef struct packed {
        logic [7:0]  ip;
        logic        halted;
        logic        pv;
        logic        ptag;
        logic [31:0] pval;
        logic        flt;
    } status_t;

    status_t expected_status[$];
    int mismatches;

    // Shadow machine state
    logic [4:0]  prog_op  [PROG_WORDS];
    logic        prog_tag [PROG_WORDS];
    logic [31:0] prog_val [PROG_WORDS];
    logic        stk_tag  [STACK_WORDS];
    logic [31:0] stk_val  [STACK_WORDS];
    logic        cs_tag   [STACK_WORDS];
    logic [31:0] cs_val   [STACK_WORDS];
    logic        mem_tag  [MEM_WORDS];
    logic [31:0] mem_val  [MEM_WORDS];
    int dtop, ctop, ip, fb;
    bit halt_flag, step_fault;

    task automatic push_word(input logic t, input logic [31:0] v);
        if (dtop >= STACK_WORDS)
            step_fault = 1;
        else
        begin
            stk_tag[dtop] = t;
            stk_val[dtop] = v;
            dtop++;
        end
    endtask

    task automatic pop_word(output bit got, output logic t, output logic [31:0] v);
        if (dtop == 0)
        begin
            step_fault = 1;
            got = 0;
            t = 0;
            v = '0;
        end
        else
        begin
            dtop--;
            got = 1;
            t = stk_tag[dtop];
            v = stk_val[dtop];
        end
    endtask

    // Apply one command beat to the shadow machine and return its status
    task automatic advance_machine(input logic c, input logic [7:0] a, input logic [4:0] op,
                                   input logic tg, input logic [31:0] v, output status_t r);
        bit pv, jumped, got, ok, inr;
        logic [4:0] o;
        logic ta, tb, ptg;
        logic [31:0] va, vb, rv, pvv;
        longint s, nb, ni, q;
        int idx;
        pv = 0;
        jumped = 0;
        ptg = 0;
        pvv = '0;
        rv = '0;
        step_fault = 0;
        if (c == tsm_pkg::CMD_LOAD)
        begin
            prog_op[a] = op;
            prog_tag[a] = tg;
            prog_val[a] = v;
        end
        else if (!halt_flag)
        begin
            o = prog_op[ip];
            s = longint'($signed(prog_val[ip]));
            case (o)
                tsm_pkg::OP_PUSH: push_word(prog_tag[ip], prog_val[ip]);
                tsm_pkg::OP_POP: pop_word(got, ta, va);
                tsm_pkg::OP_DUP:
                begin
                    pop_word(got, ta, va);
                    if (got)
                    begin
                        push_word(ta, va);
                        push_word(ta, va);
                    end
                end
                tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV,
                tsm_pkg::OP_EQ, tsm_pkg::OP_GT, tsm_pkg::OP_GE, tsm_pkg::OP_LT,
                tsm_pkg::OP_LE, tsm_pkg::OP_NE:
                begin
                    pop_word(got, ta, va);
                    pop_word(got, tb, vb);
                    if (ta && tb)
                    begin
                        case (o)
                            tsm_pkg::OP_ADD: rv = vb + va;
                            tsm_pkg::OP_SUB: rv = vb - va;
                            tsm_pkg::OP_MUL: rv = vb * va;
                            tsm_pkg::OP_DIV:
                            begin
                                // truncating divide; most negative / -1 wraps
                                if (va != 0)
                                begin
                                    q = longint'($signed(vb)) / longint'($signed(va));
                                    rv = q[31:0];
                                end
                            end
                            tsm_pkg::OP_EQ: rv = 32'(va == vb);
                            tsm_pkg::OP_GT: rv = 32'($signed(vb) > $signed(va));
                            tsm_pkg::OP_GE: rv = 32'($signed(vb) >= $signed(va));
                            tsm_pkg::OP_LT: rv = 32'($signed(vb) < $signed(va));
                            tsm_pkg::OP_LE: rv = 32'($signed(vb) <= $signed(va));
                            default: rv = 32'(va != vb);
                        endcase
                        if (o == tsm_pkg::OP_DIV && va == 0)
                            step_fault = 1;
                        else
                            push_word(1'b1, rv);
                    end
                end
                tsm_pkg::OP_JMP, tsm_pkg::OP_JIT, tsm_pkg::OP_JIF:
                begin
                    got = 1;
                    ok = 1;
                    if (o != tsm_pkg::OP_JMP)
                    begin
                        pop_word(got, ta, va);
                        ok = (o == tsm_pkg::OP_JIT) ? (va != 0) : (va == 0);
                    end
                    if (got && ok)
                    begin
                        if (s >= 0 && s < PROG_WORDS)
                        begin
                            ip = int'(s);
                            jumped = 1;
                        end
                        else
                            step_fault = 1;
                    end
                end
                tsm_pkg::OP_CALL:
                begin
                    if (s < 0 || s >= PROG_WORDS || ctop + 2 > STACK_WORDS)
                        step_fault = 1;
                    else
                    begin
                        cs_tag[ctop] = 1;
                        cs_val[ctop] = 32'(ip);
                        cs_tag[ctop + 1] = 1;
                        cs_val[ctop + 1] = 32'(fb);
                        ctop += 2;
                        fb = ctop;
                        ip = int'(s);
                        jumped = 1;
                    end
                end
                tsm_pkg::OP_RET:
                begin
                    if (fb < 2 || fb > STACK_WORDS)
                        step_fault = 1;
                    else
                    begin
                        nb = longint'($signed(cs_val[fb - 1]));
                        ni = longint'($signed(cs_val[fb - 2]));
                        if (nb < 0 || nb > STACK_WORDS || ni < 0 || ni >= PROG_WORDS)
                            step_fault = 1;
                        else
                        begin
                            ctop = fb - 2;
                            fb = int'(nb);
                            ip = int'(ni);
                        end
                    end
                end
                tsm_pkg::OP_STO:
                begin
                    pop_word(got, ta, va);
                    if (got)
                    begin
                        if (s >= -OFS && s < MEM_WORDS - OFS)
                        begin
                            mem_tag[s + OFS] = ta;
                            mem_val[s + OFS] = va;
                        end
                        else
                            step_fault = 1;
                    end
                end
                tsm_pkg::OP_RCL:
                begin
                    if (s >= -OFS && s < MEM_WORDS - OFS)
                        push_word(mem_tag[s + OFS], mem_val[s + OFS]);
                    else
                        step_fault = 1;
                end
                tsm_pkg::OP_END:
                begin
                    halt_flag = 1;
                    jumped = 1;
                end
                tsm_pkg::OP_PRN:
                begin
                    pop_word(got, ta, va);
                    if (got)
                    begin
                        pv = 1;
                        ptg = ta;
                        pvv = va;
                    end
                end
                tsm_pkg::OP_STL, tsm_pkg::OP_RCE:
                begin
                    // frame-relative slot on the call stack
                    inr = s >= 1 - fb && s < STACK_WORDS + 1 - fb;
                    idx = int'(s) + fb - 1;
                    if (o == tsm_pkg::OP_STL)
                    begin
                        pop_word(got, ta, va);
                        if (got)
                        begin
                            if (inr)
                            begin
                                cs_tag[idx] = ta;
                                cs_val[idx] = va;
                            end
                            else
                                step_fault = 1;
                        end
                    end
                    else if (inr)
                        push_word(cs_tag[idx], cs_val[idx]);
                    else
                        step_fault = 1;
                end
                tsm_pkg::OP_ALC:
                begin
                    if (s >= -ctop && s <= STACK_WORDS - ctop)
                        ctop = ctop + int'(s);
                    else
                        step_fault = 1;
                end
                tsm_pkg::OP_FRE:
                begin
                    if (s <= ctop && s >= ctop - STACK_WORDS)
                        ctop = ctop - int'(s);
                    else
                        step_fault = 1;
                end
                default: ;
            endcase
            if (!jumped)
                ip = (ip + 1 >= PROG_WORDS) ? 0 : ip + 1;
        end
        r.ip = 8'(ip);
        r.halted = halt_flag;
        r.pv = pv;
        r.ptag = ptg;
        r.pval = pvv;
        r.flt = step_fault;
    endtask

    // Compare finished beats, then predict newly accepted ones
    always @(posedge clk or negedge rst_n)
    begin
        status_t exp_st, got_st;
        if (!rst_n)
        begin
            expected_status.delete();
            dtop = 0;
            ctop = 0;
            ip = 0;
            fb = 0;
            halt_flag = 0;
            mismatches = 0;
        end
        else
        begin
            if (done)
            begin
                got_st = {instr_ptr, halted, print_valid, print_is_num, print_value, fault};
                if (expected_status.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    exp_st = expected_status.pop_front();
                    if (got_st.ip != exp_st.ip)
                    begin
                        $error("instr_ptr: expected %0d, got %0d", exp_st.ip, got_st.ip);
                        mismatches++;
                    end
                    if (got_st.halted != exp_st.halted)
                    begin
                        $error("halted: expected %0d, got %0d", exp_st.halted, got_st.halted);
                        mismatches++;
                    end
                    if (got_st.pv != exp_st.pv)
                    begin
                        $error("print_valid: expected %0d, got %0d", exp_st.pv, got_st.pv);
                        mismatches++;
                    end
                    if (got_st.ptag != exp_st.ptag)
                    begin
                        $error("print_is_num: expected %0d, got %0d", exp_st.ptag, got_st.ptag);
                        mismatches++;
                    end
                    if (got_st.pval != exp_st.pval)
                    begin
                        $error("print_value: expected %0d, got %0d",
                               $signed(exp_st.pval), $signed(got_st.pval));
                        mismatches++;
                    end
                    if (got_st.flt != exp_st.flt)
                    begin
                        $error("fault: expected %0d, got %0d", exp_st.flt, got_st.flt);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                advance_machine(cmd, load_addr, load_opcode, load_is_num, load_value, exp_st);
                expected_status.push_back(exp_st);
            end
        end
        fail_count <= mismatches;
        pending <= expected_status.size();
    end

endmodule

@@ tb/sv/tagged_stack_machine_core_tb.sv @@
// Testbench top for the tagged stack machine core: stimulus, reset and verdict.
`timescale 1ns / 100ps

module tagged_stack_machine_core_tb;

    // Unassigned opcode, expected to act as a no-op
    localparam logic [4:0] OP_SPARE = 5'd31;

    logic clk, rst_n, start, busy, cmd, done;
    logic [7:0] load_addr, instr_ptr;
    logic [4:0] load_opcode;
    logic load_is_num, halted, print_valid, print_is_num, fault;
    logic signed [31:0] load_value, print_value;
    int fail_count, pending;

    bit written [256];
    bit allow_idle;
    int cur_ip, n_loads, n_steps, n_prints, n_faults;

    tagged_stack_machine_core dut (.*);

    tagged_stack_machine_core_chk chk (.*);

    // 12 ns clock
    always
    begin
        clk = 1;
        #6;
        clk = 0;
        #6;
    end

    // Send one command beat and wait for its result beat
    task automatic send_beat(input logic c, input logic [7:0] a, input logic [4:0] op,
                             input logic tg, input logic [31:0] v);
        int gap;
        @(negedge clk);
        if (allow_idle && $urandom_range(3) == 0)
        begin
            start = 0;
            gap = $urandom_range(10, 1);
            repeat (gap) @(negedge clk);
        end
        start = 1;
        cmd = c;
        load_addr = a;
        load_opcode = op;
        load_is_num = tg;
        load_value = v;
        do @(posedge clk); while (busy);
        @(negedge clk);
        start = 0;
        cmd = $urandom_range(1);
        load_value = $urandom;
        do @(posedge clk); while (!done);
        cur_ip = instr_ptr;
        n_prints += print_valid;
        n_faults += fault;
        if (c == tsm_pkg::CMD_LOAD)
        begin
            written[a] = 1;
            n_loads++;
        end
        else
            n_steps++;
    endtask

    // Place an instruction at the pointer and run it
    task automatic run_instr(input logic [4:0] op, input logic tg, input logic [31:0] v);
        send_beat(tsm_pkg::CMD_LOAD, 8'(cur_ip), op, tg, v);
        send_beat(tsm_pkg::CMD_EXEC, 8'($urandom), 5'($urandom), 1'($urandom), $urandom);
    endtask

    // Random program word, weighted toward useful operations; never END
    task automatic pick_word(output logic [4:0] op, output logic tg, output logic [31:0] v);
        int k;
        k = $urandom_range(99);
        tg = ($urandom_range(9) != 0);
        if (k < 28)
        begin
            op = tsm_pkg::OP_PUSH;
            v = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20)) - 32'd10;
        end
        else
        begin
            op = 5'($urandom_range(31));
            if (op == tsm_pkg::OP_END)
                op = tsm_pkg::OP_DUP;
            case (op)
                tsm_pkg::OP_JMP, tsm_pkg::OP_JIT, tsm_pkg::OP_JIF, tsm_pkg::OP_CALL:
                    v = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(255));
                tsm_pkg::OP_STO, tsm_pkg::OP_RCL, tsm_pkg::OP_STL, tsm_pkg::OP_RCE:
                    v = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(72)) - 32'd8;
                tsm_pkg::OP_ALC, tsm_pkg::OP_FRE:
                    v = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(12)) - 32'd4;
                default: v = $urandom;
            endcase
        end
    endtask

    initial
    begin
        logic [4:0] op;
        logic tg;
        logic [31:0] v;
        rst_n = 0;
        start = 0;
        cmd = 0;
        load_addr = 0;
        load_opcode = 0;
        load_is_num = 0;
        load_value = 0;
        allow_idle = 1;
        cur_ip = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Fill data memory and the call stack so every later read hits written data
        for (int k = 0; k < 64; k++)
        begin
            run_instr(tsm_pkg::OP_PUSH, 1'($urandom), $urandom);
            run_instr(tsm_pkg::OP_STO, 1, 32'(k - tsm_pkg::MEM_OFFSET));
        end
        run_instr(tsm_pkg::OP_ALC, 1, 32'd64);
        for (int k = 1; k <= 64; k++)
        begin
            run_instr(tsm_pkg::OP_PUSH, 1'($urandom), $urandom);
            run_instr(tsm_pkg::OP_STL, 1, 32'(k));
        end
        run_instr(tsm_pkg::OP_FRE, 1, 32'd64);

        // Directed corners: wrap divide, divide by zero, underflow, tags, bad jump, calls, spare opcode, bad recall
        run_instr(tsm_pkg::OP_PUSH, 1, 32'h8000_0000);
        run_instr(tsm_pkg::OP_PUSH, 1, 32'hFFFF_FFFF);
        run_instr(tsm_pkg::OP_DIV, 1, 0);
        run_instr(tsm_pkg::OP_PRN, 0, 32'h7FFF_FFFF);
        run_instr(tsm_pkg::OP_PUSH, 1, 32'd5);
        run_instr(tsm_pkg::OP_PUSH, 1, 32'd0);
        run_instr(tsm_pkg::OP_DIV, 1, 0);
        run_instr(tsm_pkg::OP_POP, 1, 0);
        run_instr(tsm_pkg::OP_DUP, 1, 0);
        run_instr(tsm_pkg::OP_PRN, 1, 0);
        run_instr(tsm_pkg::OP_PUSH, 0, 32'd7);
        run_instr(tsm_pkg::OP_PUSH, 1, 32'd3);
        run_instr(tsm_pkg::OP_ADD, 1, 0);
        run_instr(tsm_pkg::OP_JMP, 1, 32'd256);
        run_instr(tsm_pkg::OP_CALL, 1, 32'd200);
        run_instr(tsm_pkg::OP_RET, 1, 0);
        run_instr(OP_SPARE, 1, 0);
        run_instr(tsm_pkg::OP_RCL, 1, 32'hFFFF_FFF9);

        // Random: mostly instructions placed at the pointer, plus stray loads and executes of words already there
        for (int i = 0; i < 700; i++)
        begin
            if (i > 600)
                allow_idle = 0;
            pick_word(op, tg, v);
            if ($urandom_range(9) < 3)
                send_beat(tsm_pkg::CMD_LOAD, 8'($urandom), op, tg, v);
            else if (!written[cur_ip] || $urandom_range(9) < 6)
                run_instr(op, tg, v);
            else
                send_beat(tsm_pkg::CMD_EXEC, 8'($urandom), 5'($urandom), 1'($urandom),
                          $urandom);
        end

        // Halt, then execute and load while halted
        run_instr(tsm_pkg::OP_END, 1, 0);
        send_beat(tsm_pkg::CMD_EXEC, 0, tsm_pkg::OP_PUSH, 0, 0);
        send_beat(tsm_pkg::CMD_LOAD, 8'hFF, OP_SPARE, 1, 32'hFFFF_FFFF);
        send_beat(tsm_pkg::CMD_EXEC, 0, tsm_pkg::OP_PUSH, 0, 0);

        repeat (60) @(posedge clk);
        $display("covered %0d loads and %0d executes, %0d prints, %0d faulting beats",
                 n_loads, n_steps, n_prints, n_faults);
        if (fail_count == 0 && pending == 0)
            $display("tagged_stack_machine_core_tb passed");
        else
            $display("tagged_stack_machine_core_tb failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("tagged_stack_machine_core_tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tsm_pkg.sv
rtl/tsm_ram.sv
rtl/tagged_stack_machine_core.sv
tb/sv/tagged_stack_machine_core_chk.sv
tb/sv/tagged_stack_machine_core_tb.sv
